// File: hdl/tlfb_pkg.sv
// Package for the telemetry and log frame builder: frame constants, command and
// register codes, and the job record passed from the front end to the byte serialiser.
// Depends on nothing; the front end, queue, serialiser, top level and bench import it.
`default_nettype none

package tlfb_pkg;

    localparam logic [7:0] FRAME_START   = 8'hAA;
    localparam logic [7:0] CAP_LIMIT     = 8'd241;
    localparam logic [7:0] TELEM_LEN     = 8'd29;
    localparam logic [7:0] LOG_FIXED_LEN = 8'd14;

    // Default depth of the job queue between the front end and the serialiser.
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_TELEM_TYPE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOG_TYPE   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_MSG    = 2'd2;

    // Byte positions within a job.
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_HDR_LAST    = 5'd10;
    localparam logic [POS_W-1:0] POS_SENSOR_LAST = 5'd26;
    localparam logic [POS_W-1:0] POS_TELEM_STATE = 5'd27;
    localparam logic [POS_W-1:0] POS_TELEM_LAST  = 5'd28;
    localparam logic [POS_W-1:0] POS_LOG_CODE    = 5'd11;
    localparam logic [POS_W-1:0] POS_LOG_KEEP    = 5'd12;
    localparam logic [POS_W-1:0] POS_LOG_CSUM    = 5'd13;
    localparam logic [POS_W-1:0] POS_SENSOR_0    = 5'd11;

    typedef enum logic [1:0] {
        CMD_TELEM     = 2'd0,
        CMD_LOG_START = 2'd1,
        CMD_LOG_BYTE  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_TELEM   = 2'd0,
        JOB_LOG_HDR = 2'd1,
        JOB_LOG_BYTE = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [31:0]       seq;
        logic [7:0]        len;
        logic [31:0]       ts;
        logic [7:0]        type_code;
        logic [0:15][7:0]  sensor_bytes;
        logic [7:0]        data;
        logic [7:0]        keep;
        logic              close;
        logic              emit;
    } job_t;

endpackage

`default_nettype wire

// File: hdl/tlfb_item_if.sv
// Input channel of the frame builder: valid/ready handshake and the item fields.
// Stand-alone; no package needed.
`default_nettype none

interface tlfb_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] timestamp;
    logic [15:0] acc_x;
    logic [15:0] acc_y;
    logic [15:0] acc_z;
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [15:0] pressure_raw;
    logic [15:0] altitude_raw;
    logic [7:0]  small_byte;
    logic [7:0]  message_length;

    modport source (
        output valid, cmd, timestamp, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
               pressure_raw, altitude_raw, small_byte, message_length,
        input  ready
    );
    modport sink (
        input  valid, cmd, timestamp, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
               pressure_raw, altitude_raw, small_byte, message_length,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/tlfb_frame_if.sv
// Output channel of the frame builder: valid/ready handshake, one frame byte per beat.
// Stand-alone; no package needed.
`default_nettype none

interface tlfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink (input valid, out_byte, frame_end, output ready);
endinterface

`default_nettype wire

// File: hdl/tlfb_front.sv
// Front end: accepts items, checks them against the open log frame, keeps the
// sequence number and message counters, and issues one job per item with output.
// Depends on tlfb_pkg and tlfb_item_if.
`default_nettype none

module tlfb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tlfb_item_if.sink          item,
    input  wire logic [7:0]    telemetry_type_code,
    input  wire logic [7:0]    log_type_code,
    input  wire logic [7:0]    max_message_length,
    output tlfb_pkg::job_t     push_job,
    output logic               push_valid,
    input  wire logic          push_ready
);
    import tlfb_pkg::*;

    logic [31:0] seq_reg, seq_next;
    logic [7:0]  take_reg, take_next;
    logic [7:0]  keep_reg, keep_next;
    logic        open_reg, open_next;

    logic        accept;
    logic [7:0]  cap;
    logic [7:0]  keep;
    logic [7:0]  take_dec;

    assign item.ready = push_ready;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        cap      = (max_message_length > CAP_LIMIT) ? CAP_LIMIT : max_message_length;
        keep     = (item.message_length > cap) ? cap : item.message_length;
        take_dec = (take_reg != 8'd0) ? take_reg - 8'd1 : 8'd0;

        push_job              = '0;
        push_job.seq          = seq_reg;
        push_job.ts           = item.timestamp;
        push_job.sensor_bytes = {item.acc_x, item.acc_y, item.acc_z, item.gyro_x,
                                 item.gyro_y, item.gyro_z, item.pressure_raw,
                                 item.altitude_raw};
        push_job.data         = item.small_byte;
        push_job.keep         = keep;

        push_valid = 1'b0;
        seq_next   = seq_reg;
        take_next  = take_reg;
        keep_next  = keep_reg;
        open_next  = open_reg;

        unique case (cmd_t'(item.cmd))
            CMD_TELEM:
            begin
                push_job.kind      = JOB_TELEM;
                push_job.len       = TELEM_LEN;
                push_job.type_code = telemetry_type_code;
                push_job.close     = 1'b1;
                if (accept && !open_reg)
                begin
                    push_valid = 1'b1;
                    seq_next   = seq_reg + 32'd1;
                end
            end
            CMD_LOG_START:
            begin
                push_job.kind      = JOB_LOG_HDR;
                push_job.len       = LOG_FIXED_LEN + keep;
                push_job.type_code = log_type_code;
                push_job.close     = (item.message_length == 8'd0);
                if (accept && !open_reg)
                begin
                    push_valid = 1'b1;
                    seq_next   = seq_reg + 32'd1;
                    if (item.message_length != 8'd0)
                    begin
                        take_next = item.message_length;
                        keep_next = keep;
                        open_next = 1'b1;
                    end
                end
            end
            CMD_LOG_BYTE:
            begin
                push_job.kind  = JOB_LOG_BYTE;
                push_job.emit  = (keep_reg != 8'd0);
                push_job.close = (take_dec == 8'd0);
                if (accept && open_reg)
                begin
                    // A byte past the cap that does not close the frame yields no job.
                    push_valid = push_job.emit || push_job.close;
                    take_next  = take_dec;
                    keep_next  = push_job.emit ? keep_reg - 8'd1 : keep_reg;
                    if (push_job.close)
                    begin
                        keep_next = 8'd0;
                        open_next = 1'b0;
                    end
                end
            end
            default:
            begin
                push_job.kind = JOB_LOG_BYTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            take_reg <= '0;
            keep_reg <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            seq_reg  <= seq_next;
            take_reg <= take_next;
            keep_reg <= keep_next;
            open_reg <= open_next;
        end
    end

`ifndef SYNTHESIS
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (take_reg != 8'd0))
        else $error("log frame open with no announced bytes left");
    a_keep_within_take: assert property (@(posedge clk) disable iff (!rst_n)
        keep_reg <= take_reg)
        else $error("more message bytes to send than announced bytes left");
    a_closed_keeps_none: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (keep_reg == 8'd0))
        else $error("message bytes pending with no log frame open");
`endif

endmodule

`default_nettype wire

// File: hdl/tlfb_queue.sv
// Short job queue between the front end and the serialiser, so either side can stall.
// Depends on tlfb_pkg.
`default_nettype none

module tlfb_queue #(
    parameter int unsigned DEPTH = tlfb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  tlfb_pkg::job_t       push_job,
    input  wire logic            push_valid,
    output logic                 push_ready,
    output tlfb_pkg::job_t       pop_job,
    output logic                 pop_valid,
    input  wire logic            pop_ready
);
    import tlfb_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue holds more entries than its depth");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("job queue pointers disagree while empty");
`endif

endmodule

`default_nettype wire

// File: hdl/tlfb_back.sv
// Serialiser: walks the job at the head of the queue byte by byte, keeps the frame
// checksum and drives the registered output channel. Depends on tlfb_pkg, tlfb_frame_if.
`default_nettype none

module tlfb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  tlfb_pkg::job_t     job,
    input  wire logic          job_valid,
    output logic               job_ready,
    tlfb_frame_if.source       frame
);
    import tlfb_pkg::*;

    logic [POS_W-1:0] idx_reg;
    logic [7:0]       csum_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] last_pos;
    logic [3:0]       sensor_idx;
    logic [7:0]       byte_val;
    logic             is_csum;
    logic             is_last;
    logic             produce;

    assign frame.valid     = out_valid_reg;
    assign frame.out_byte  = out_byte_reg;
    assign frame.frame_end = out_end_reg;

    always_comb
    begin
        // A message byte job that is past the cap starts straight at its checksum.
        pos = idx_reg;
        if (job.kind == JOB_LOG_BYTE && !job.emit)
            pos = idx_reg + 1'b1;
        sensor_idx = 4'(pos - POS_SENSOR_0);

        unique case (job.kind)
            JOB_TELEM:    last_pos = POS_TELEM_LAST;
            JOB_LOG_HDR:  last_pos = job.close ? POS_LOG_CSUM : POS_LOG_KEEP;
            JOB_LOG_BYTE: last_pos = job.close ? 5'd1 : 5'd0;
            default:      last_pos = '0;
        endcase

        is_csum  = 1'b0;
        byte_val = csum_reg;
        if (job.kind == JOB_LOG_BYTE)
        begin
            is_csum  = (pos != '0);
            byte_val = is_csum ? csum_reg : job.data;
        end
        else if (pos <= POS_HDR_LAST)
        begin
            case (pos)
                5'd0:    byte_val = FRAME_START;
                5'd1:    byte_val = job.seq[31:24];
                5'd2:    byte_val = job.seq[23:16];
                5'd3:    byte_val = job.seq[15:8];
                5'd4:    byte_val = job.seq[7:0];
                5'd5:    byte_val = job.len;
                5'd6:    byte_val = job.ts[31:24];
                5'd7:    byte_val = job.ts[23:16];
                5'd8:    byte_val = job.ts[15:8];
                5'd9:    byte_val = job.ts[7:0];
                default: byte_val = job.type_code;
            endcase
        end
        else if (job.kind == JOB_TELEM)
        begin
            if (pos <= POS_SENSOR_LAST)
                byte_val = job.sensor_bytes[sensor_idx];
            else if (pos == POS_TELEM_STATE)
                byte_val = job.data;
            else
                is_csum = 1'b1;
        end
        else
        begin
            if (pos == POS_LOG_CODE)
                byte_val = job.data;
            else if (pos == POS_LOG_KEEP)
                byte_val = job.keep;
            else
                is_csum = 1'b1;
        end
    end

    assign produce   = job_valid && (!out_valid_reg || frame.ready);
    assign is_last   = (pos == last_pos);
    assign job_ready = produce && is_last;

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_byte_reg <= byte_val;
            out_end_reg  <= is_csum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            csum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (produce)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? '0 : idx_reg + 1'b1;
                // The start byte opens a new frame and is left out of the checksum.
                if (job.kind != JOB_LOG_BYTE && pos == '0)
                    csum_reg <= '0;
                else if (!is_csum)
                    csum_reg <= csum_reg ^ byte_val;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> job_valid)
        else $error("job left the queue before all its bytes were sent");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= POS_TELEM_LAST)
        else $error("byte position beyond the longest frame");
`endif

endmodule

`default_nettype wire

// File: hdl/telemetry_log_frame_builder.sv
// Telemetry and log frame builder, top level; instantiates tlfb_front, tlfb_queue and
// tlfb_back, and uses tlfb_pkg, tlfb_item_if and tlfb_frame_if.
// Every frame goes out one byte per beat: 0xAA, the big-endian sequence number, the length
// byte, the big-endian timestamp, the type byte, the body, then the XOR checksum, marked by
// frame_end. A telemetry item gives 29 bytes; a log start gives 13 bytes, or 14 when the
// announced length is zero; a message byte gives 0, 1 or 2 bytes. The output is byte-wide
// and registered, so throughput is one byte per cycle when a job waits and the receiver is
// ready. Items are taken while the job queue (QUEUE_DEPTH entries) has room, including while
// the output is stalled; items that produce nothing still need a queue slot free to be taken.
// Configuration registers are written through wr_en, wr_index and wr_data, by the user only
// while the block is idle (not enforced by the block); there is no clearing pass after reset.
`default_nettype none

module telemetry_log_frame_builder #(
    parameter int unsigned QUEUE_DEPTH = tlfb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tlfb_item_if.sink                            item,
    tlfb_frame_if.source                         frame,
    input  wire logic                            wr_en,
    input  wire logic [tlfb_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [7:0]                      wr_data
);
    import tlfb_pkg::*;

    logic [7:0] telem_type_reg;
    logic [7:0] log_type_reg;
    logic [7:0] max_msg_reg;

    job_t push_job, pop_job;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            telem_type_reg <= 8'd1;
            log_type_reg   <= 8'd2;
            max_msg_reg    <= 8'd64;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TELEM_TYPE: telem_type_reg <= wr_data;
                REG_LOG_TYPE:   log_type_reg   <= wr_data;
                REG_MAX_MSG:    max_msg_reg    <= wr_data;
                default:        ;
            endcase
        end
    end

    tlfb_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item                (item),
        .telemetry_type_code (telem_type_reg),
        .log_type_code       (log_type_reg),
        .max_message_length  (max_msg_reg),
        .push_job            (push_job),
        .push_valid          (push_valid),
        .push_ready          (push_ready)
    );

    tlfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    tlfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (pop_job),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .frame     (frame)
    );

endmodule

`default_nettype wire

// File: bench/tb_telemetry_log_frame_builder.sv
`timescale 1ns / 1ps
// Self-checking bench for telemetry_log_frame_builder: drives telemetry, log start and
// message items, predicts every frame byte and checks the output stream beat by beat.
// Depends on tlfb_pkg, tlfb_item_if, tlfb_frame_if and the block's RTL.

module tb_telemetry_log_frame_builder;
    import tlfb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT = 1000;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [31:0]      timestamp;
        logic [0:7][15:0] sensor_words;
        logic [7:0]       small_byte;
        logic [7:0]       message_length;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [7:0]           wr_data;

    tlfb_item_if  item_bus ();
    tlfb_frame_if frame_bus ();

    telemetry_log_frame_builder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_bus),
        .frame    (frame_bus),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Mirror of the configuration and of the frame state.
    logic [7:0]  telem_type_code;
    logic [7:0]  log_type_code;
    logic [7:0]  max_msg_len;
    logic [31:0] next_seq;
    logic [7:0]  frame_xor;
    logic [7:0]  take_left;
    logic [7:0]  keep_left;
    logic        log_open;

    frame_item_t pending_items[$];
    frame_byte_t expected_frame_bytes[$];
    int          sender_idle_pct;
    int          receiver_idle_pct;
    bit          item_beat_taken = 1'b0;
    int          stall_cycles = 0;
    int          error_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        // The count always grows; the log is capped so that a broken build does not flood it.
        if (error_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic void add_byte(input logic [7:0] value, input logic last);
        expected_frame_bytes.push_back({value, last});
    endfunction

    function automatic void add_body(input logic [7:0] value);
        frame_xor = frame_xor ^ value;
        add_byte(value, 1'b0);
    endfunction

    function automatic void add_word32(input logic [31:0] word);
        add_body(word[31:24]);
        add_body(word[23:16]);
        add_body(word[15:8]);
        add_body(word[7:0]);
    endfunction

    function automatic void start_header(input logic [7:0] frame_len,
                                         input logic [31:0] stamp,
                                         input logic [7:0] type_code);
        frame_xor = '0;
        add_byte(FRAME_START, 1'b0);
        add_word32(next_seq);
        next_seq = next_seq + 32'd1;
        add_body(frame_len);
        add_word32(stamp);
        add_body(type_code);
    endfunction

    function automatic void close_frame();
        add_byte(frame_xor, 1'b1);
    endfunction

    function automatic void predict_frame_bytes(input frame_item_t it);
        logic [7:0] cap;
        logic [7:0] keep;
        case (it.cmd)
            CMD_TELEM:
            begin
                if (!log_open)
                begin
                    start_header(TELEM_LEN, it.timestamp, telem_type_code);
                    for (int w = 0; w < 8; w++)
                    begin
                        add_body(it.sensor_words[w][15:8]);
                        add_body(it.sensor_words[w][7:0]);
                    end
                    add_body(it.small_byte);
                    close_frame();
                end
            end
            CMD_LOG_START:
            begin
                if (!log_open)
                begin
                    // The cap never exceeds what the length byte can carry.
                    cap = (max_msg_len > CAP_LIMIT) ? CAP_LIMIT : max_msg_len;
                    keep = (it.message_length > cap) ? cap : it.message_length;
                    start_header(LOG_FIXED_LEN + keep, it.timestamp, log_type_code);
                    add_body(it.small_byte);
                    add_body(keep);
                    if (it.message_length == 8'd0)
                    begin
                        close_frame();
                    end
                    else
                    begin
                        take_left = it.message_length;
                        keep_left = keep;
                        log_open = 1'b1;
                    end
                end
            end
            CMD_LOG_BYTE:
            begin
                if (log_open)
                begin
                    if (keep_left != 8'd0)
                    begin
                        add_body(it.small_byte);
                        keep_left = keep_left - 8'd1;
                    end
                    if (take_left != 8'd0)
                    begin
                        take_left = take_left - 8'd1;
                    end
                    if (take_left == 8'd0)
                    begin
                        close_frame();
                        keep_left = '0;
                        log_open = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic frame_item_t random_item(input logic [1:0] cmd);
        frame_item_t it;
        it.cmd = cmd;
        it.timestamp = $urandom;
        for (int w = 0; w < 8; w++)
        begin
            it.sensor_words[w] = 16'($urandom_range(0, 65535));
        end
        it.small_byte = 8'($urandom_range(0, 255));
        it.message_length = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // A log start and all of its announced message beats, optionally with items out of
    // place scattered through the body.
    task automatic queue_log_message(input logic [7:0] msg_len, inout int counted,
                                     input bit with_noise);
        frame_item_t it;
        int n;
        it = random_item(CMD_LOG_START);
        it.message_length = msg_len;
        pending_items.push_back(it);
        counted++;
        for (n = 0; n < msg_len; n++)
        begin
            if (with_noise && $urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: pending_items.push_back(random_item(CMD_TELEM));
                    1: pending_items.push_back(random_item(CMD_LOG_START));
                    default: pending_items.push_back(random_item(CMD_UNUSED));
                endcase
            end
            pending_items.push_back(random_item(CMD_LOG_BYTE));
            counted++;
        end
    endtask

    task automatic queue_random_traffic(input int target);
        int counted;
        int roll;
        logic [7:0] msg_len;
        counted = 0;
        while (counted < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                pending_items.push_back(random_item(CMD_TELEM));
                counted++;
            end
            else if (roll < 88)
            begin
                // Mostly short messages; now and then a longer one.
                if ($urandom_range(0, 24) == 0)
                begin
                    msg_len = 8'($urandom_range(0, 40));
                end
                else
                begin
                    msg_len = 8'($urandom_range(0, 12));
                end
                queue_log_message(msg_len, counted, 1'b1);
            end
            else if (roll < 94)
            begin
                pending_items.push_back(random_item(CMD_LOG_BYTE));
            end
            else
            begin
                pending_items.push_back(random_item(CMD_UNUSED));
            end
        end
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] index, input logic [7:0] value);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= index;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        case (index)
            REG_TELEM_TYPE: telem_type_code = value;
            REG_LOG_TYPE:   log_type_code = value;
            REG_MAX_MSG:    max_msg_len = value;
            default:
            begin
            end
        endcase
    endtask

    // Items that produce nothing may still sit in the block once the last byte is out,
    // hence the pause after the queues have emptied.
    task automatic wait_for_idle();
        while (pending_items.size() != 0 || expected_frame_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: a beat is held until it is taken; a new one is offered unless the sender idles.
    always @(negedge clk)
    begin
        if (!item_bus.valid || item_beat_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                item_bus.valid <= 1'b1;
                item_bus.cmd <= pending_items[0].cmd;
                item_bus.timestamp <= pending_items[0].timestamp;
                item_bus.acc_x <= pending_items[0].sensor_words[0];
                item_bus.acc_y <= pending_items[0].sensor_words[1];
                item_bus.acc_z <= pending_items[0].sensor_words[2];
                item_bus.gyro_x <= pending_items[0].sensor_words[3];
                item_bus.gyro_y <= pending_items[0].sensor_words[4];
                item_bus.gyro_z <= pending_items[0].sensor_words[5];
                item_bus.pressure_raw <= pending_items[0].sensor_words[6];
                item_bus.altitude_raw <= pending_items[0].sensor_words[7];
                item_bus.small_byte <= pending_items[0].small_byte;
                item_bus.message_length <= pending_items[0].message_length;
            end
            else
            begin
                item_bus.valid <= 1'b0;
            end
        end
        item_beat_taken = 1'b0;
        frame_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Monitor: predicts on every item beat and checks every frame beat.
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                predict_frame_bytes(pending_items.pop_front());
                item_beat_taken = 1'b1;
            end
            if (frame_bus.valid && frame_bus.ready)
            begin
                if (expected_frame_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("byte %02h with nothing expected",
                                              frame_bus.out_byte));
                end
                else
                begin
                    want = expected_frame_bytes.pop_front();
                    if (frame_bus.out_byte !== want.value)
                    begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  frame_bus.out_byte, want.value));
                    end
                    if (frame_bus.frame_end !== want.last)
                    begin
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  frame_bus.frame_end, want.last));
                    end
                end
            end
            if ((item_bus.valid && item_bus.ready) || (frame_bus.valid && frame_bus.ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        frame_item_t it;
        int counted;
        counted = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_TELEM_TYPE;
        wr_data = '0;
        item_bus.valid = 1'b0;
        item_bus.cmd = CMD_TELEM;
        item_bus.timestamp = '0;
        item_bus.acc_x = '0;
        item_bus.acc_y = '0;
        item_bus.acc_z = '0;
        item_bus.gyro_x = '0;
        item_bus.gyro_y = '0;
        item_bus.gyro_z = '0;
        item_bus.pressure_raw = '0;
        item_bus.altitude_raw = '0;
        item_bus.small_byte = '0;
        item_bus.message_length = '0;
        frame_bus.ready = 1'b0;
        sender_idle_pct = 38;
        receiver_idle_pct = 78;
        telem_type_code = 8'd1;
        log_type_code = 8'd2;
        max_msg_len = 8'd64;
        next_seq = '0;
        frame_xor = '0;
        take_left = '0;
        keep_left = '0;
        log_open = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Telemetry frames with every field at its lowest and then its highest value.
        it = random_item(CMD_TELEM);
        it.timestamp = '0;
        it.sensor_words = '0;
        it.small_byte = '0;
        pending_items.push_back(it);
        it.timestamp = '1;
        it.sensor_words = '1;
        it.small_byte = '1;
        pending_items.push_back(it);
        // An empty log message closes its frame straight away.
        it = random_item(CMD_LOG_START);
        it.timestamp = '1;
        it.small_byte = '1;
        it.message_length = 8'd0;
        pending_items.push_back(it);
        // A stray message byte and the unused command, with no log open.
        pending_items.push_back(random_item(CMD_LOG_BYTE));
        pending_items.push_back(random_item(CMD_UNUSED));
        // A short log with items out of place inside its body.
        it = random_item(CMD_LOG_START);
        it.timestamp = '0;
        it.small_byte = '0;
        it.message_length = 8'd3;
        pending_items.push_back(it);
        pending_items.push_back(random_item(CMD_TELEM));
        pending_items.push_back(random_item(CMD_LOG_START));
        pending_items.push_back(random_item(CMD_UNUSED));
        it = random_item(CMD_LOG_BYTE);
        it.small_byte = 8'h00;
        pending_items.push_back(it);
        it.small_byte = 8'hFF;
        pending_items.push_back(it);
        pending_items.push_back(random_item(CMD_LOG_BYTE));
        wait_for_idle();

        // A tight cap, so that message bytes past it are taken but dropped.
        write_register(REG_MAX_MSG, 8'd2);
        write_register(REG_TELEM_TYPE, 8'h00);
        write_register(REG_LOG_TYPE, 8'hFF);
        queue_log_message(8'd5, counted, 1'b0);
        pending_items.push_back(random_item(CMD_TELEM));
        queue_random_traffic(8);
        wait_for_idle();

        sender_idle_pct = 78;
        receiver_idle_pct = 38;
        write_register(REG_TELEM_TYPE, 8'hFF);
        write_register(REG_LOG_TYPE, 8'h00);
        write_register(REG_MAX_MSG, 8'd0);
        queue_random_traffic(8);
        wait_for_idle();

        // A cap above the limit acts as the limit; the longest message fills the length byte.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_register(REG_MAX_MSG, 8'hFF);
        write_register(REG_TELEM_TYPE, 8'($urandom_range(0, 255)));
        write_register(REG_LOG_TYPE, 8'($urandom_range(0, 255)));
        queue_log_message(8'd242, counted, 1'b0);
        wait_for_idle();

        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/tlfb_pkg.sv
hdl/tlfb_item_if.sv
hdl/tlfb_frame_if.sv
hdl/tlfb_front.sv
hdl/tlfb_queue.sv
hdl/tlfb_back.sv
hdl/telemetry_log_frame_builder.sv
bench/tb_telemetry_log_frame_builder.sv
